// ===== rtl/core/swpt_pkg.sv =====
// Shared types and constants of the sliding-window packet table.
package swpt_pkg;

   localparam int SLOTS_MAX = 16;
   localparam int PDU_MAX   = 1500;
   localparam int SLOT_W    = $clog2(SLOTS_MAX);
   localparam int WIN_W     = SLOT_W + 1;
   localparam int SEQ_W     = 32;
   localparam int LEN_W     = 11;
   localparam int ACT_W     = 3;
   localparam int STAT_W    = 3;
   localparam int MOD_STEPS = SEQ_W / 2;

   typedef enum logic [ACT_W-1:0] {
      ACT_ENQUEUE = 3'd0,
      ACT_ACK     = 3'd1,
      ACT_LOOKUP  = 3'd2,
      ACT_STORE   = 3'd3,
      ACT_CLEAR   = 3'd4,
      ACT_RESTART = 3'd5
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_CLOSED    = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_BEYOND    = 3'd3,
      ST_DUPLICATE = 3'd4,
      ST_FULL      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SCAN,
      FSM_MOD,
      FSM_DONE
   } fsm_type;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [SEQ_W-1:0] seq_num;
      logic [LEN_W-1:0] pdu_length;
   } item_type;

   // Handshake between the front queue and the back sequencer.
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

// ===== rtl/core/sliding_window_packet_table.sv =====
// Top level of the sliding-window packet table for a selective-repeat link.
//
// Requests arrive on the req_ stream: tuser carries the action, tdata the
// sequence number and payload length. Each request gives exactly one result
// transfer on the rsp_ stream, in order, with the status in tuser and the
// slot, stored length, closed flag, lower-edge slot and both window edges in
// tdata. The slot addresses an external payload buffer.
// A two-entry queue sits between the request side and the sequencer, so
// requests are taken while an earlier result still waits at the output.
// Enqueue, restart and unused actions go from the execute state straight to the result.
// Acknowledge (at a width above one), lookup, store and clear walk at most the W slots
// of a window of W slots, one per cycle. An acknowledge that moves the window then works
// out the lower-edge slot, two remainder bits per cycle.
// A stalled receiver holds the result register; once the queue fills,
// req_tready falls. Reset (synchronous) empties the queue, clears the table and
// sets the window width to eight; a csr_ write also restarts the table.
module sliding_window_packet_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,   // window width in slots
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,     // action
   input  logic [47:0] req_tdata,     // seq_num, pdu_length, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,     // status
   output logic [87:0] rsp_tdata      // slot, slot_length, closed, lowest_slot,
                                      // window_low, window_high, zero pad
);
   import swpt_pkg::*;

   queue_out_type q;
   logic          q_pop;

   swpt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_out      (q),
      .q_pop      (q_pop)
   );

   swpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_in        (q),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ===== rtl/core/swpt_front.sv =====
// Front part: accepts request transfers, saturates the length and queues them.
module swpt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [2:0]         req_tuser,
   input  logic [47:0]        req_tdata,
   output swpt_pkg::queue_out_type q_out,
   input  logic               q_pop
);
   import swpt_pkg::*;

   item_type   buf_ff [2];
   item_type   buf_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;
   item_type   new_item;

   always_comb begin
      new_item.action  = req_tuser;
      new_item.seq_num = req_tdata[SEQ_W-1:0];
      if (req_tdata[SEQ_W+LEN_W-1:SEQ_W] > LEN_W'(PDU_MAX)) begin
         new_item.pdu_length = LEN_W'(PDU_MAX);
      end else begin
         new_item.pdu_length = req_tdata[SEQ_W+LEN_W-1:SEQ_W];
      end
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && (count_ff != 2'd0);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = buf_ff[rd_ptr_ff];

   always_comb begin
      buf_in    = buf_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         buf_in[wr_ptr_ff] = new_item;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/core/swpt_back.sv =====
// Back part: slot table, window state and the sequencer that carries out each operation.
module swpt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [4:0]         csr_wr_data,
   input  swpt_pkg::queue_out_type q_in,
   output logic               q_pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [2:0]         rsp_tuser,
   output logic [87:0]        rsp_tdata
);
   import swpt_pkg::*;

   logic [SEQ_W-1:0]  seq_ff [SLOTS_MAX];
   logic [SEQ_W-1:0]  seq_in [SLOTS_MAX];
   logic [LEN_W-1:0]  len_ff [SLOTS_MAX];
   logic [LEN_W-1:0]  len_in [SLOTS_MAX];
   logic [4:0]        wsize_ff, wsize_in;
   logic [SLOT_W-1:0] next_slot_ff, next_slot_in;
   logic [SEQ_W-1:0]  sent_ff, sent_in;
   logic [SEQ_W-1:0]  lower_ff, lower_in;
   logic [SEQ_W-1:0]  upper_ff, upper_in;
   logic              closed_ff, closed_in;
   logic [SLOT_W-1:0] lowest_ff, lowest_in;
   fsm_type           state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  slen_ff, slen_in;
   logic              found_ff, found_in;
   logic [SEQ_W-1:0]  div_ff, div_in;
   logic [WIN_W-1:0]  rem_ff, rem_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   logic              rv_ff, rv_in;
   logic [2:0]        ru_ff, ru_in;
   logic [87:0]       rd_ff, rd_in;

   logic [WIN_W-1:0]  w;
   logic [WIN_W-1:0]  w_cfg;
   logic              hit;
   logic              last;
   logic [SLOT_W-1:0] ns0;
   logic [SEQ_W-1:0]  sent_nx;
   logic [SEQ_W-1:0]  upper_ack;
   logic [WIN_W-1:0]  rem_a;
   logic [WIN_W-1:0]  rem_b;

   function automatic logic [WIN_W-1:0] clamp_w(input logic [4:0] ws);
      logic [WIN_W-1:0] r;
      if (ws == 5'd0) begin
         r = WIN_W'(1);
      end else if ({1'b0, ws} > 6'(SLOTS_MAX)) begin
         r = WIN_W'(SLOTS_MAX);
      end else begin
         r = WIN_W'(ws);
      end
      return r;
   endfunction

   // One restoring step of the remainder; the remainder always stays below w.
   function automatic logic [WIN_W-1:0] mod_step(input logic [WIN_W-1:0] r,
                                                 input logic b,
                                                 input logic [WIN_W-1:0] d);
      logic [WIN_W:0] t;
      t = {r, b};
      if (t >= {1'b0, d}) begin
         t = t - {1'b0, d};
      end
      return t[WIN_W-1:0];
   endfunction

   assign w         = clamp_w(wsize_ff);
   assign w_cfg     = clamp_w(csr_wr_data);
   assign hit       = (seq_ff[idx_ff] == cur_ff.seq_num);
   assign last      = ({1'b0, idx_ff} + WIN_W'(1)) == w;
   assign ns0       = ((w == WIN_W'(1)) || ({1'b0, next_slot_ff} >= w)) ? '0 : next_slot_ff;
   assign sent_nx   = sent_ff + SEQ_W'(1);
   assign upper_ack = cur_ff.seq_num + SEQ_W'(w);
   assign rem_a     = mod_step(rem_ff, div_ff[SEQ_W-1], w);
   assign rem_b     = mod_step(rem_a, div_ff[SEQ_W-2], w);

   always_comb begin
      seq_in       = seq_ff;
      len_in       = len_ff;
      wsize_in     = wsize_ff;
      next_slot_in = next_slot_ff;
      sent_in      = sent_ff;
      lower_in     = lower_ff;
      upper_in     = upper_ff;
      closed_in    = closed_ff;
      lowest_in    = lowest_ff;
      state_in     = state_ff;
      cur_in       = cur_ff;
      idx_in       = idx_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      slen_in      = slen_ff;
      found_in     = found_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;
      rv_in        = rv_ff && !rsp_tready;
      ru_in        = ru_ff;
      rd_in        = rd_ff;

      case (state_ff)
         FSM_IDLE: begin
            if (q_in.valid) begin
               q_pop     = 1'b1;
               cur_in    = q_in.item;
               idx_in    = '0;
               status_in = ST_OK;
               slot_in   = '0;
               slen_in   = '0;
               found_in  = 1'b0;
               state_in  = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            state_in = FSM_DONE;
            case (cur_ff.action)
               ACT_ENQUEUE: begin
                  if (closed_ff) begin
                     status_in = ST_CLOSED;
                  end else begin
                     if (w == WIN_W'(1)) begin
                        closed_in = 1'b1;
                     end
                     seq_in[ns0] = cur_ff.seq_num;
                     len_in[ns0] = cur_ff.pdu_length;
                     slot_in     = ns0;
                     next_slot_in = (({1'b0, ns0} + WIN_W'(1)) == w) ? '0 : ns0 + SLOT_W'(1);
                     sent_in     = sent_nx;
                     if (sent_nx == upper_ff) begin
                        closed_in = 1'b1;
                     end
                  end
               end
               ACT_ACK: begin
                  if (w == WIN_W'(1)) begin
                     closed_in = 1'b0;
                  end else begin
                     state_in = FSM_SCAN;
                  end
               end
               ACT_LOOKUP, ACT_STORE: begin
                  state_in = FSM_SCAN;
               end
               ACT_CLEAR: begin
                  status_in = ST_NOT_FOUND;
                  state_in  = FSM_SCAN;
               end
               ACT_RESTART: begin
                  for (int i = 0; i < SLOTS_MAX; i++) begin
                     seq_in[i] = '0;
                     len_in[i] = '0;
                  end
                  next_slot_in = '0;
                  sent_in      = '0;
                  lower_in     = '0;
                  upper_in     = SEQ_W'(w);
                  closed_in    = 1'b0;
                  lowest_in    = '0;
               end
               default: begin
               end
            endcase
         end
         FSM_SCAN: begin
            idx_in = idx_ff + SLOT_W'(1);
            case (cur_ff.action)
               ACT_ACK: begin
                  if (hit) begin
                     slot_in = idx_ff;
                     if (cur_ff.seq_num > upper_ff) begin
                        status_in = ST_BEYOND;
                        state_in  = FSM_DONE;
                     end else begin
                        lower_in = cur_ff.seq_num;
                        upper_in = upper_ack;
                        if (sent_ff != upper_ack) begin
                           closed_in = 1'b0;
                        end
                        div_in   = cur_ff.seq_num;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = FSM_MOD;
                     end
                  end else if (last) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = FSM_DONE;
                  end
               end
               ACT_LOOKUP: begin
                  if (hit) begin
                     slot_in  = idx_ff;
                     slen_in  = len_ff[idx_ff];
                     state_in = FSM_DONE;
                  end else if (last) begin
                     status_in = ST_NOT_FOUND;
                     state_in  = FSM_DONE;
                  end
               end
               ACT_STORE: begin
                  if (hit) begin
                     status_in = ST_DUPLICATE;
                     slot_in   = idx_ff;
                     state_in  = FSM_DONE;
                  end else if (len_ff[idx_ff] == '0) begin
                     seq_in[idx_ff] = cur_ff.seq_num;
                     len_in[idx_ff] = cur_ff.pdu_length;
                     status_in = ST_OK;
                     slot_in   = idx_ff;
                     state_in  = FSM_DONE;
                  end else if (last) begin
                     status_in = ST_FULL;
                     state_in  = FSM_DONE;
                  end
               end
               ACT_CLEAR: begin
                  if (hit) begin
                     seq_in[idx_ff] = '0;
                     len_in[idx_ff] = '0;
                     if (!found_ff) begin
                        found_in  = 1'b1;
                        status_in = ST_OK;
                        slot_in   = idx_ff;
                     end
                  end
                  if (last) begin
                     state_in = FSM_DONE;
                  end
               end
               default: begin
                  state_in = FSM_DONE;
               end
            endcase
         end
         FSM_MOD: begin
            // Two remainder bits per cycle from the most significant end.
            rem_in = rem_b;
            div_in = {div_ff[SEQ_W-3:0], 2'b00};
            cnt_in = cnt_ff + SLOT_W'(1);
            if (cnt_ff == SLOT_W'(MOD_STEPS - 1)) begin
               lowest_in = rem_b[SLOT_W-1:0];
               state_in  = FSM_DONE;
            end
         end
         FSM_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in    = 1'b1;
               ru_in    = status_ff;
               rd_in    = {4'd0, upper_ff, lower_ff, lowest_ff, closed_ff, slen_ff, slot_ff};
               state_in = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase

      // A register write restarts the table with the new width.
      if (csr_wr_en) begin
         wsize_in = csr_wr_data;
         for (int i = 0; i < SLOTS_MAX; i++) begin
            seq_in[i] = '0;
            len_in[i] = '0;
         end
         next_slot_in = '0;
         sent_in      = '0;
         lower_in     = '0;
         upper_in     = SEQ_W'(w_cfg);
         closed_in    = 1'b0;
         lowest_in    = '0;
      end
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tuser  = ru_ff;
   assign rsp_tdata  = rd_ff;

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      slen_ff   <= slen_in;
      found_ff  <= found_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      ru_ff     <= ru_in;
      rd_ff     <= rd_in;
      if (reset) begin
         for (int i = 0; i < SLOTS_MAX; i++) begin
            seq_ff[i] <= '0;
            len_ff[i] <= '0;
         end
         wsize_ff     <= 5'd8;
         next_slot_ff <= '0;
         sent_ff      <= '0;
         lower_ff     <= '0;
         upper_ff     <= SEQ_W'(8);
         closed_ff    <= 1'b0;
         lowest_ff    <= '0;
         state_ff     <= FSM_IDLE;
         rv_ff        <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         len_ff       <= len_in;
         wsize_ff     <= wsize_in;
         next_slot_ff <= next_slot_in;
         sent_ff      <= sent_in;
         lower_ff     <= lower_in;
         upper_ff     <= upper_in;
         closed_ff    <= closed_in;
         lowest_ff    <= lowest_in;
         state_ff     <= state_in;
         rv_ff        <= rv_in;
      end
   end

endmodule

// ===== rtl/core/swpt_checker.sv =====
// Port-level assertions for the sliding-window packet table, bound to the top level.
module swpt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [2:0]  rsp_tuser,
   input logic [87:0] rsp_tdata
);
   import swpt_pkg::*;

   // A stalled result transfer keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= 3'(ST_FULL)))
      else $error("result status out of range");

   // A result with a status other than OK reports no stored length.
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != 3'(ST_OK)) |-> (rsp_tdata[14:4] == 11'd0))
      else $error("length reported on a failed operation");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind sliding_window_packet_table swpt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb.sv =====
// Self-checking testbench of the sliding-window packet table: random and directed stream traffic.
`timescale 1ns / 100ps

module tb;
   import swpt_pkg::*;

   typedef struct {
      logic [2:0]  action;
      logic [31:0] seq;
      logic [10:0] len;
   } window_op_type;

   typedef struct {
      logic [2:0]  status;
      logic [3:0]  slot;
      logic [10:0] slot_len;
      logic        closed;
      logic [3:0]  low_slot;
      logic [31:0] win_low;
      logic [31:0] win_high;
   } window_res_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;
   logic [87:0] rsp_tdata;

   sliding_window_packet_table u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata)
   );

   // Shadow copy of the table.
   logic [31:0] tbl_seq [SLOTS_MAX];
   logic [10:0] tbl_len [SLOTS_MAX];
   int          tbl_next;
   logic [31:0] tbl_sent;
   logic [31:0] tbl_lower;
   logic [31:0] tbl_upper;
   logic        tbl_closed;
   logic [4:0]  tbl_wsize;

   window_op_type  pending_ops[$];
   window_res_type expected_res[$];

   int  errors = 0;
   int  results_seen = 0;
   int  status_seen [8];
   bit  quiet = 0;
   bit  long_hold_req = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   int  hold_left = 0;
   int  stall_cycles = 0;

   // Stimulus generator state.
   logic [31:0] gen_seq;
   logic [31:0] seq_pool[$];
   int          gen_w;

   function automatic int width_now();
      if (tbl_wsize < 1) return 1;
      if (tbl_wsize > SLOTS_MAX) return SLOTS_MAX;
      return tbl_wsize;
   endfunction

   function automatic void table_restart();
      for (int i = 0; i < SLOTS_MAX; i++) begin
         tbl_seq[i] = '0;
         tbl_len[i] = '0;
      end
      tbl_next   = 0;
      tbl_sent   = '0;
      tbl_lower  = '0;
      tbl_upper  = 32'(width_now());
      tbl_closed = 1'b0;
   endfunction

   function automatic int find_seq(logic [31:0] s);
      for (int i = 0; i < width_now(); i++)
         if (tbl_seq[i] == s) return i;
      return -1;
   endfunction

   function automatic window_res_type apply_op(window_op_type op);
      window_res_type r;
      int          w;
      int          f;
      logic [10:0] len;
      bit          hit;
      w   = width_now();
      len = (op.len > PDU_MAX) ? 11'(PDU_MAX) : op.len;
      r.status   = ST_OK;
      r.slot     = '0;
      r.slot_len = '0;
      case (op.action)
         ACT_ENQUEUE: begin
            if (tbl_closed) begin
               r.status = ST_CLOSED;
            end else begin
               if (w == 1) begin
                  tbl_closed = 1'b1;
                  tbl_next   = 0;
               end
               if (tbl_next >= w) tbl_next = 0;
               tbl_seq[tbl_next] = op.seq;
               tbl_len[tbl_next] = len;
               r.slot   = 4'(tbl_next);
               tbl_next = (tbl_next + 1) % w;
               tbl_sent = tbl_sent + 1;
               if (tbl_sent == tbl_upper) tbl_closed = 1'b1;
            end
         end
         ACT_ACK: begin
            if (w == 1) begin
               tbl_closed = 1'b0;
            end else begin
               f = find_seq(op.seq);
               if (f < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.slot = 4'(f);
                  if (op.seq > tbl_upper) begin
                     r.status = ST_BEYOND;
                  end else begin
                     tbl_lower = op.seq;
                     tbl_upper = op.seq + 32'(w);
                     if (tbl_sent != tbl_upper) tbl_closed = 1'b0;
                  end
               end
            end
         end
         ACT_LOOKUP: begin
            f = find_seq(op.seq);
            if (f < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.slot     = 4'(f);
               r.slot_len = tbl_len[f];
            end
         end
         ACT_STORE: begin
            r.status = ST_FULL;
            for (int i = 0; i < w; i++) begin
               if (tbl_seq[i] == op.seq) begin
                  r.status = ST_DUPLICATE;
                  r.slot   = 4'(i);
                  break;
               end
               if (tbl_len[i] == 0) begin
                  tbl_seq[i] = op.seq;
                  tbl_len[i] = len;
                  r.status   = ST_OK;
                  r.slot     = 4'(i);
                  break;
               end
            end
         end
         ACT_CLEAR: begin
            hit      = 0;
            r.status = ST_NOT_FOUND;
            for (int i = 0; i < w; i++) begin
               if (tbl_seq[i] == op.seq) begin
                  if (!hit) begin
                     r.status = ST_OK;
                     r.slot   = 4'(i);
                  end
                  hit = 1;
                  tbl_seq[i] = '0;
                  tbl_len[i] = '0;
               end
            end
         end
         ACT_RESTART: table_restart();
         default: ;
      endcase
      r.closed   = tbl_closed;
      r.low_slot = 4'(tbl_lower % 32'(w));
      r.win_low  = tbl_lower;
      r.win_high = tbl_upper;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: at most one nonblocking write of req_tvalid per edge.
   always @(posedge clock) begin
      window_op_type op;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= '0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            op.action = req_tuser;
            op.seq    = req_tdata[31:0];
            op.len    = req_tdata[42:32];
            expected_res.push_back(apply_op(op));
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_ops.size() > 0) begin
               op = pending_ops.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= op.action;
               req_tdata  <= {5'b0, op.len, op.seq};
               if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure.
   always @(posedge clock) begin
      window_res_type got;
      window_res_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tuser;
            got.slot     = rsp_tdata[3:0];
            got.slot_len = rsp_tdata[14:4];
            got.closed   = rsp_tdata[15];
            got.low_slot = rsp_tdata[19:16];
            got.win_low  = rsp_tdata[51:20];
            got.win_high = rsp_tdata[83:52];
            results_seen++;
            status_seen[got.status]++;
            if (expected_res.size() == 0) begin
               $error("result transfer with no outstanding request");
               errors++;
            end else begin
               want = expected_res.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  errors++;
               end
               if (got.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, got.slot);
                  errors++;
               end
               if (got.slot_len !== want.slot_len) begin
                  $error("slot_length: expected %0d, got %0d", want.slot_len, got.slot_len);
                  errors++;
               end
               if (got.closed !== want.closed) begin
                  $error("closed: expected %0d, got %0d", want.closed, got.closed);
                  errors++;
               end
               if (got.low_slot !== want.low_slot) begin
                  $error("lowest_slot: expected %0d, got %0d", want.low_slot, got.low_slot);
                  errors++;
               end
               if (got.win_low !== want.win_low) begin
                  $error("window_low: expected %h, got %h", want.win_low, got.win_low);
                  errors++;
               end
               if (got.win_high !== want.win_high) begin
                  $error("window_high: expected %h, got %h", want.win_high, got.win_high);
                  errors++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 400;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) recv_gap = $urandom_range(1, 15);
         end
      end
   end

   // Watchdog on cycles with work outstanding but no transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (pending_ops.size() == 0 && expected_res.size() == 0 && !req_tvalid))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= 5000) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_op(logic [2:0] act, logic [31:0] s, logic [10:0] len);
      window_op_type op;
      op.action = act;
      op.seq    = s;
      op.len    = len;
      pending_ops.push_back(op);
      if (act == ACT_ENQUEUE || act == ACT_STORE) begin
         seq_pool.push_back(s);
         if (seq_pool.size() > 24) void'(seq_pool.pop_front());
      end
   endtask

   task automatic wait_drained();
      while (pending_ops.size() > 0 || expected_res.size() > 0 || req_tvalid)
         @(negedge clock);
      // Every result has been checked here; the bench then idles before going on.
      repeat (60) @(negedge clock);
   endtask

   task automatic write_window(logic [4:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tbl_wsize = value;
      table_restart();
      @(posedge clock);
      csr_wr_en <= 1'b0;
      gen_seq = '0;
      gen_w   = width_now();
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_seq();
      if (seq_pool.size() > 0 && $urandom_range(0, 4) != 0)
         return seq_pool[$urandom_range(0, seq_pool.size() - 1)];
      return $urandom();
   endfunction

   function automatic logic [10:0] pick_len();
      if ($urandom_range(0, 5) == 0) return 11'($urandom_range(1501, 2047));
      return 11'($urandom_range(0, PDU_MAX));
   endfunction

   task automatic random_ops(int count);
      int r;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            queue_op(ACT_ENQUEUE, gen_seq, pick_len());
            gen_seq = gen_seq + 1;
         end else if (r < 55) begin
            if ($urandom_range(0, 9) == 0)
               queue_op(ACT_ACK, $urandom(), '0);
            else
               queue_op(ACT_ACK, gen_seq - 32'($urandom_range(1, gen_w + 1)), '0);
         end else if (r < 67) begin
            queue_op(ACT_LOOKUP, pick_seq(), '0);
         end else if (r < 79) begin
            queue_op(ACT_STORE, pick_seq(),
                     ($urandom_range(0, 3) == 0) ? 11'd0 : pick_len());
         end else if (r < 89) begin
            queue_op(ACT_CLEAR, pick_seq(), '0);
         end else if (r < 92) begin
            queue_op(ACT_RESTART, $urandom(), 11'($urandom()));
            gen_seq = '0;
         end else begin
            queue_op(3'($urandom_range(0, 7)), $urandom(), 11'($urandom()));
         end
      end
   endtask

   initial begin
      logic [4:0] widths [6];
      widths = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd8};
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      tbl_wsize   = 5'd8;
      table_restart();
      gen_seq = '0;
      gen_w   = 8;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening at the reset width of eight.
      queue_op(ACT_ENQUEUE, 32'hFFFF_FFFF, 11'h7FF);
      queue_op(ACT_ENQUEUE, 32'h0, 11'd0);
      queue_op(ACT_LOOKUP, 32'hFFFF_FFFF, '0);
      queue_op(ACT_LOOKUP, 32'd12345, '0);
      queue_op(ACT_STORE, 32'hFFFF_FFFF, 11'd5);
      queue_op(ACT_STORE, 32'd77, 11'd1500);
      queue_op(ACT_ACK, 32'd99, '0);
      queue_op(ACT_ACK, 32'hFFFF_FFFF, '0);
      queue_op(ACT_CLEAR, 32'hFFFF_FFFF, '0);
      queue_op(ACT_CLEAR, 32'd5, '0);
      queue_op(3'd6, 32'hA5A5_A5A5, 11'h555);
      queue_op(3'd7, 32'h5A5A_5A5A, 11'h2AA);
      for (int i = 1; i <= 6; i++) queue_op(ACT_ENQUEUE, 32'(i), 11'(i * 100));
      queue_op(ACT_ENQUEUE, 32'd7, 11'd7);
      queue_op(ACT_ACK, 32'd1, '0);
      queue_op(ACT_LOOKUP, 32'd77, '0);
      queue_op(ACT_RESTART, 32'h0, '0);
      gen_seq = 32'd0;
      random_ops(100);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_window(widths[p]);
         if (p == 5) quiet = 1;
         if (p == 2) begin
            random_ops(30);
            long_hold_req = 1;
            random_ops(75);
         end else begin
            random_ops(90);
         end
         wait_drained();
      end

      $display("Covered window widths 8, 1, 16, 0, 31, 3 with %0d results checked.",
               results_seen);
      $display("Status counts ok/closed/notfound/beyond/dup/full: %0d %0d %0d %0d %0d %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3],
               status_seen[4], status_seen[5]);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
